>>> rtl/lrb_pkg.sv
// shared types, constants and the shift register step for the lfsr random bits block
package lrb_pkg;

  // beat widths
  localparam int IN_DATA_W  = 136;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 64;
  localparam int WORD_W     = 64;
  localparam int LFSR_W     = 128;
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 64;
  localparam int MAX_BITS   = 64;
  localparam int CNT_MIN_W  = 7;

  // request kinds carried on in_tuser
  typedef enum logic [1:0] {
    FUNC_RESEED = 2'd0,
    FUNC_BITS   = 2'd1,
    FUNC_RANGED = 2'd2,
    FUNC_NOP    = 2'd3
  } func_t;

  // register index taken from cfg_paddr[3]
  localparam logic REG_SEED_LOW  = 1'b0;
  localparam logic REG_SEED_HIGH = 1'b1;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic step;
    logic emit;
  } lrb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cnt_zero;
  } lrb_status_t;

  // one step: shift right, feedback from bits 0, 1, 2 and 7 of the shifted value
  function automatic logic [LFSR_W-1:0] lfsr_advance(input logic [LFSR_W-1:0] s);
    logic [LFSR_W-1:0] sh;
    logic              fb;
    sh = s >> 1;
    fb = sh[0] ^ sh[1] ^ sh[2] ^ sh[7];
    return {fb, sh[LFSR_W-2:0]};
  endfunction

endpackage

>>> rtl/lrb_regs.sv
// seed registers behind the apb-style configuration port
module lrb_regs
  import lrb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output logic [WORD_W-1:0]     seed_low,
  output logic [WORD_W-1:0]     seed_high
);

  logic [WORD_W-1:0] seed_low_r;
  logic [WORD_W-1:0] seed_high_r;
  logic              wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // register writes in the access phase
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_low_r  <= WORD_W'(1);
      seed_high_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_paddr[3])
        REG_SEED_LOW:  seed_low_r  <= cfg_pwdata;
        REG_SEED_HIGH: seed_high_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (cfg_paddr[3])
      REG_SEED_LOW:  cfg_prdata = seed_low_r;
      REG_SEED_HIGH: cfg_prdata = seed_high_r;
      default:       cfg_prdata = '0;
    endcase
  end

  assign seed_low  = seed_low_r;
  assign seed_high = seed_high_r;

endmodule

>>> rtl/lrb_ctrl.sv
// request sequencer: accept, step until the count runs out, hand off the result
module lrb_ctrl
  import lrb_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  output logic        out_tvalid,
  input  logic        out_tready,
  input  lrb_status_t status,
  output lrb_cmd_t    cmd
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (status.cnt_zero) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.step = 1'b1;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> rtl/lrb_dp.sv
// shift register, bit collector, serial remainder and result register
module lrb_dp
  import lrb_pkg::*;
#(
  parameter int WARMUP_STEPS = 128
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  lrb_cmd_t              cmd,
  output lrb_status_t           status,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic [IN_USER_W-1:0]  in_tuser,
  input  logic [WORD_W-1:0]     seed_low,
  input  logic [WORD_W-1:0]     seed_high,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_error
);

  localparam int CNT_W = ($clog2(WARMUP_STEPS + 1) > CNT_MIN_W) ?
                         $clog2(WARMUP_STEPS + 1) : CNT_MIN_W;

  // request fields
  func_t             in_func;
  logic [6:0]        in_bit_count;
  logic              in_force;
  logic [WORD_W-1:0] in_low;
  logic [WORD_W-1:0] in_high;

  assign in_func      = func_t'(in_tuser);
  assign in_bit_count = in_tdata[6:0];
  assign in_force     = in_tdata[7];
  assign in_low       = in_tdata[71:8];
  assign in_high      = in_tdata[135:72];

  logic [LFSR_W-1:0] lfsr_r;
  logic [WORD_W-1:0] acc_r;
  logic [WORD_W-1:0] rem_r;
  logic [WORD_W-1:0] span_r;
  logic [WORD_W-1:0] low_r;
  logic [CNT_W-1:0]  cnt_r;
  func_t             func_r;
  logic              force_r;
  logic              err_r;
  logic              full_r;
  logic [WORD_W-1:0] out_data_r;
  logic              out_err_r;

  // request check and step count at load
  logic              load_err;
  logic [CNT_W-1:0]  load_cnt;
  logic [WORD_W-1:0] load_span;

  assign load_span = in_high - in_low + WORD_W'(1);

  always_comb begin
    load_err = 1'b0;
    load_cnt = '0;
    case (in_func)
      FUNC_RESEED: load_cnt = CNT_W'(WARMUP_STEPS);
      FUNC_BITS: begin
        if (in_bit_count == 7'd0 || in_bit_count > 7'(MAX_BITS)) begin
          load_err = 1'b1;
        end else begin
          load_cnt = CNT_W'(in_bit_count);
        end
      end
      FUNC_RANGED: begin
        if (in_low > in_high) begin
          load_err = 1'b1;
        end else begin
          load_cnt = CNT_W'(MAX_BITS);
        end
      end
      default: load_cnt = '0;
    endcase
  end

  // one shift step, new bit into the collector and the running remainder
  logic [LFSR_W-1:0] lfsr_step;
  logic              new_bit;
  logic [WORD_W:0]   rem_shift;
  logic [WORD_W-1:0] rem_step;

  assign lfsr_step = lfsr_advance(lfsr_r);
  assign new_bit   = lfsr_step[0];
  assign rem_shift = {rem_r, new_bit};

  always_comb begin
    if (rem_shift >= {1'b0, span_r}) begin
      rem_step = WORD_W'(rem_shift - {1'b0, span_r});
    end else begin
      rem_step = rem_shift[WORD_W-1:0];
    end
  end

  // shift register state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= LFSR_W'(1);
    end else if (cmd.load && in_func == FUNC_RESEED) begin
      lfsr_r <= {seed_high, seed_low};
    end else if (cmd.step) begin
      lfsr_r <= lfsr_step;
    end
  end

  // step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.load) begin
      cnt_r <= load_cnt;
    end else if (cmd.step) begin
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign status.cnt_zero = (cnt_r == '0);

  // captured request and working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r  <= in_func;
      force_r <= in_force;
      err_r   <= load_err;
      low_r   <= in_low;
      span_r  <= load_span;
      full_r  <= (load_span == '0);
      acc_r   <= '0;
      rem_r   <= '0;
    end else if (cmd.step) begin
      acc_r <= {acc_r[WORD_W-2:0], new_bit};
      rem_r <= rem_step;
    end
  end

  // result select
  logic [WORD_W-1:0] result;

  always_comb begin
    result = '0;
    if (!err_r) begin
      case (func_r)
        FUNC_BITS:   result = acc_r | {force_r, {(WORD_W-1){1'b0}}};
        FUNC_RANGED: result = full_r ? acc_r : (low_r + rem_r);
        default:     result = '0;
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= result;
      out_err_r  <= err_r;
    end
  end

  assign out_tdata = out_data_r;
  assign out_error = out_err_r;

endmodule

>>> rtl/lfsr_random_bits_ranged_top.sv
// 128-bit lfsr random source with bits, ranged and reseed requests
//
// One request beat in, one result beat out. A request runs n shift steps, n
// being the bit count for a bits request, 64 for a ranged request,
// WARMUP_STEPS for a reseed, and 0 for a rejected request or the unused kind;
// a new request is taken only once the result is in the output register.
// The shift register advances one step per cycle, and a ranged request folds
// each new bit into a serial restoring remainder in that same cycle. A
// finished result is held in an output register until it is taken. Seeds are
// written through the apb-style port at byte address 0 (low half) and 8 (high
// half) and take effect on the next reseed request; write them only while no
// request is in progress.
module lfsr_random_bits_ranged_top
  import lrb_pkg::*;
#(
  parameter int WARMUP_STEPS = 128
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  // request channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // bit_count[6:0], force_top_bit[7], range_low[71:8], range_high[135:72]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  // result channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // value[63:0]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // error[0]
  output logic [0:0]            out_tuser,
  // configuration port
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  logic [WORD_W-1:0] seed_low;
  logic [WORD_W-1:0] seed_high;
  lrb_cmd_t          cmd;
  lrb_status_t       status;
  logic              out_error;

  lrb_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .seed_low    (seed_low),
    .seed_high   (seed_high)
  );

  lrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  lrb_dp #(
    .WARMUP_STEPS (WARMUP_STEPS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .seed_low  (seed_low),
    .seed_high (seed_high),
    .out_tdata (out_tdata),
    .out_error (out_error)
  );

  assign out_tuser = out_error;

endmodule

>>> rtl/lrb_checker.sv
// port-level checks for the lfsr random bits block, bound to the top level
module lrb_checker
  import lrb_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [0:0]            out_tuser
);

  // a stalled result beat stays offered
  a_out_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser))
    else $error("result payload changed while stalled");

  // a rejected request reports a zero value
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == '0)
    else $error("error beat with nonzero value");

  // one request at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while previous one in progress");

endmodule

bind lfsr_random_bits_ranged_top lrb_checker u_lrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
